// ----- sv/u16u8_pkg.sv -----
// Shared types, constants and UTF-8 encoding helpers for the UTF-16/32 to UTF-8 transcoder.
// No dependencies; the design files of the block use this package by scoped names, the checker does not.
`timescale 1ns / 1ps

package u16u8_pkg;

   localparam int CpWidth    = 21;
   localparam int UnitWidth  = 32;
   localparam int QueueDepth = 2;

   localparam logic [CpWidth-1:0]   ReplChar     = 21'h00FFFD;
   localparam logic [CpWidth-1:0]   SuppBase     = 21'h010000;
   localparam logic [UnitWidth-1:0] ScalarMax    = 32'h0010FFFF;
   localparam logic [UnitWidth-1:0] SurrFirst    = 32'h0000D800;
   localparam logic [UnitWidth-1:0] SurrLast     = 32'h0000DFFF;
   localparam logic [5:0]           HighSurrTag  = 6'b110110;
   localparam logic [5:0]           LowSurrTag   = 6'b110111;
   localparam logic [1:0]           ContPrefix   = 2'b10;
   localparam logic [2:0]           Lead2Prefix  = 3'b110;
   localparam logic [3:0]           Lead3Prefix  = 4'b1110;
   localparam logic [4:0]           Lead4Prefix  = 5'b11110;

   // Byte count minus one of an encoded code point
   typedef enum logic [1:0] {
      LEN_1 = 2'd0,
      LEN_2 = 2'd1,
      LEN_3 = 2'd2,
      LEN_4 = 2'd3
   } len_type;

   // One queued word: optional replacement char, then optional code point
   typedef struct packed {
      logic               has_repl;
      logic               has_cp;
      logic [CpWidth-1:0] cp;
      logic               eos;
   } entry_type;

   function automatic len_type cp_len(input logic [CpWidth-1:0] cp);
      len_type len;
      if (cp <= 21'h00007F) begin
         len = LEN_1;
      end else if (cp <= 21'h0007FF) begin
         len = LEN_2;
      end else if (cp <= 21'h00FFFF) begin
         len = LEN_3;
      end else begin
         len = LEN_4;
      end
      return len;
   endfunction

   // Byte number idx of the encoding of cp, whose length code is len
   function automatic logic [7:0] enc_byte(input logic [CpWidth-1:0] cp,
                                           input len_type len,
                                           input logic [1:0] idx);
      logic [7:0] b;
      logic [1:0] sh;
      sh = 2'(len) - idx;
      if (idx == 2'd0) begin
         unique case (len)
            LEN_1: b = {1'b0, cp[6:0]};
            LEN_2: b = {Lead2Prefix, cp[10:6]};
            LEN_3: b = {Lead3Prefix, cp[15:12]};
            LEN_4: b = {Lead4Prefix, cp[20:18]};
            default: b = {1'b0, cp[6:0]};
         endcase
      end else begin
         unique case (sh)
            2'd0: b = {ContPrefix, cp[5:0]};
            2'd1: b = {ContPrefix, cp[11:6]};
            2'd2: b = {ContPrefix, cp[17:12]};
            default: b = {ContPrefix, cp[5:0]};
         endcase
      end
      return b;
   endfunction

endpackage

// ----- sv/utf16_to_utf8_transcoder.sv -----
// Top level of the UTF-16/32 to UTF-8 transcoder: front end, word queue, byte serializer.
// Depends on u16u8_pkg, u16u8_front, u16u8_queue and u16u8_back.
`timescale 1ns / 1ps
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_stall  code_unit[31:0], end_of_string
//   rsp_     out        rsp_valid/rsp_stall  out_byte[7:0], run_last, string_last
//   csr_     in         csr_valid/csr_ready  unit_mode (csr_ready is always high)
//
// The front end accepts a word while the word queue is not full and yields 0 to 6 bytes;
// the serializer sends one byte per cycle while the result register is not stalled, and a
// held high surrogate pushes no word into the queue. The first byte passes the queue slot,
// the serializer's code point register and the result register on its way to the port.
// Reset is synchronous and clears the held surrogate, mode, queue and result register.
// req_stall rises only while the word queue is full; rsp_stall freezes the result register.

module utf16_to_utf8_transcoder #(
   parameter int QUEUE_DEPTH = u16u8_pkg::QueueDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_code_unit,
   input  logic        req_end_of_string,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_run_last,
   output logic        rsp_string_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_unit_mode
);

   u16u8_pkg::entry_type push_entry, head_entry;
   logic                 q_push, q_pop, q_empty, q_full;

   assign csr_ready = 1'b1;

   u16u8_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_code_unit     (req_code_unit),
      .req_end_of_string (req_end_of_string),
      .csr_valid         (csr_valid),
      .csr_unit_mode     (csr_unit_mode),
      .q_full            (q_full),
      .q_push            (q_push),
      .q_entry           (push_entry)
   );

   u16u8_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .head_entry (head_entry),
      .empty      (q_empty),
      .full       (q_full)
   );

   u16u8_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_entry         (head_entry),
      .q_empty         (q_empty),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_run_last    (rsp_run_last),
      .rsp_string_last (rsp_string_last)
   );

endmodule

// ----- sv/u16u8_front.sv -----
// Front end: accepts code units, pairs surrogates, sanitizes code points, pushes queue words.
// Depends on u16u8_pkg.
`timescale 1ns / 1ps

module u16u8_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [u16u8_pkg::UnitWidth-1:0]   req_code_unit,
   input  logic                              req_end_of_string,
   input  logic                              csr_valid,
   input  logic                              csr_unit_mode,
   input  logic                              q_full,
   output logic                              q_push,
   output u16u8_pkg::entry_type              q_entry
);

   logic       mode_ff, mode_in;
   logic       pending_ff, pending_in;
   logic [9:0] held_ff, held_in;
   logic       accept;
   logic       is_hi, is_lo, is_surr32;
   logic [15:0] unit16;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign unit16    = req_code_unit[15:0];
   assign is_hi     = (unit16[15:10] == u16u8_pkg::HighSurrTag);
   assign is_lo     = (unit16[15:10] == u16u8_pkg::LowSurrTag);
   assign is_surr32 = (req_code_unit >= u16u8_pkg::SurrFirst) &&
                      (req_code_unit <= u16u8_pkg::SurrLast);

   // Classify the unit and decide what the back end emits
   always_comb begin
      mode_in    = mode_ff;
      pending_in = pending_ff;
      held_in    = held_ff;
      q_entry    = '{has_repl: 1'b0, has_cp: 1'b0, cp: '0, eos: req_end_of_string};
      if (mode_ff) begin
         q_entry.has_cp = 1'b1;
         if ((req_code_unit > u16u8_pkg::ScalarMax) || is_surr32) begin
            q_entry.cp = u16u8_pkg::ReplChar;
         end else begin
            q_entry.cp = req_code_unit[u16u8_pkg::CpWidth-1:0];
         end
      end else if (pending_ff && is_lo) begin
         q_entry.has_cp = 1'b1;
         q_entry.cp     = u16u8_pkg::SuppBase + {1'b0, held_ff, unit16[9:0]};
      end else begin
         q_entry.has_repl = pending_ff;
         if (is_hi) begin
            if (req_end_of_string) begin
               q_entry.has_cp = 1'b1;
               q_entry.cp     = u16u8_pkg::ReplChar;
            end else begin
               pending_in = 1'b1;
               held_in    = unit16[9:0];
            end
         end else if (is_lo) begin
            q_entry.has_cp = 1'b1;
            q_entry.cp     = u16u8_pkg::ReplChar;
         end else begin
            q_entry.has_cp = 1'b1;
            q_entry.cp     = {5'd0, unit16};
         end
      end
      if (mode_ff || !(pending_ff && is_lo) && !is_hi || is_hi && req_end_of_string) begin
         pending_in = pending_ff && !accept ? pending_ff : pending_in;
      end
      if (!accept) begin
         pending_in = pending_ff;
         held_in    = held_ff;
      end else if (!(is_hi && !req_end_of_string && !mode_ff)) begin
         pending_in = 1'b0;
      end
      // A register write drops any held surrogate
      if (csr_valid) begin
         mode_in    = csr_unit_mode;
         pending_in = 1'b0;
      end
   end

   assign q_push = accept && (q_entry.has_repl || q_entry.has_cp);

   // Hold mode and surrogate state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= 1'b0;
         pending_ff <= 1'b0;
      end else begin
         mode_ff    <= mode_in;
         pending_ff <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
   end

endmodule

// ----- sv/u16u8_queue.sv -----
// Short word queue that decouples the front end from the byte serializer.
// Depends on u16u8_pkg.
`timescale 1ns / 1ps

module u16u8_queue #(
   parameter int DEPTH = u16u8_pkg::QueueDepth
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  u16u8_pkg::entry_type push_entry,
   input  logic                 pop,
   output u16u8_pkg::entry_type head_entry,
   output logic                 empty,
   output logic                 full
);

   localparam int PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntWidth = $clog2(DEPTH + 1);
   localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(DEPTH - 1);

   u16u8_pkg::entry_type slot_ff [DEPTH];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign empty      = (count_ff == '0);
   assign full       = (count_ff == CntWidth'(DEPTH));
   assign do_push    = push && !full;
   assign do_pop     = pop && !empty;
   assign head_entry = slot_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- sv/u16u8_back.sv -----
// Back end: takes queue words and serializes their UTF-8 bytes into the result register.
// Depends on u16u8_pkg.
`timescale 1ns / 1ps

module u16u8_back (
   input  logic                 clock,
   input  logic                 reset,
   input  u16u8_pkg::entry_type q_entry,
   input  logic                 q_empty,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_run_last,
   output logic                 rsp_string_last
);

   logic                          act_ff, act_in;
   logic                          more_ff, more_in;
   logic                          eos_ff, eos_in;
   logic [u16u8_pkg::CpWidth-1:0] cp_ff, cp_in;
   logic [u16u8_pkg::CpWidth-1:0] next_ff, next_in;
   u16u8_pkg::len_type            len_ff, len_in;
   logic [1:0]                    idx_ff, idx_in;
   logic                          rv_ff, rv_in;
   logic [7:0]                    byte_ff, byte_in;
   logic                          rl_ff, rl_in;
   logic                          sl_ff, sl_in;
   logic                          out_free, emit, last_byte, finish;

   assign out_free  = !rv_ff || !rsp_stall;
   assign emit      = act_ff && out_free;
   assign last_byte = (idx_ff == 2'(len_ff));
   assign finish    = emit && last_byte && !more_ff;
   assign q_pop     = !q_empty && (!act_ff || finish);

   // Emit one byte per cycle while the result register is free, then advance to the next code point or word
   always_comb begin
      act_in  = act_ff;
      more_in = more_ff;
      eos_in  = eos_ff;
      cp_in   = cp_ff;
      next_in = next_ff;
      len_in  = len_ff;
      idx_in  = idx_ff;
      rv_in   = rv_ff;
      byte_in = byte_ff;
      rl_in   = rl_ff;
      sl_in   = sl_ff;
      if (out_free) begin
         rv_in = emit;
      end
      if (emit) begin
         byte_in = u16u8_pkg::enc_byte(cp_ff, len_ff, idx_ff);
         rl_in   = last_byte && !more_ff;
         sl_in   = last_byte && !more_ff && eos_ff;
         if (!last_byte) begin
            idx_in = idx_ff + 2'd1;
         end else if (more_ff) begin
            cp_in   = next_ff;
            len_in  = u16u8_pkg::cp_len(next_ff);
            idx_in  = 2'd0;
            more_in = 1'b0;
         end else begin
            act_in = 1'b0;
         end
      end
      // Load a fresh word from the queue
      if (q_pop) begin
         act_in  = 1'b1;
         idx_in  = 2'd0;
         eos_in  = q_entry.eos;
         next_in = q_entry.cp;
         if (q_entry.has_repl) begin
            cp_in   = u16u8_pkg::ReplChar;
            more_in = q_entry.has_cp;
         end else begin
            cp_in   = q_entry.cp;
            more_in = 1'b0;
         end
         len_in = u16u8_pkg::cp_len(cp_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff  <= 1'b0;
         more_ff <= 1'b0;
         rv_ff   <= 1'b0;
      end else begin
         act_ff  <= act_in;
         more_ff <= more_in;
         rv_ff   <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      eos_ff  <= eos_in;
      cp_ff   <= cp_in;
      next_ff <= next_in;
      len_ff  <= len_in;
      idx_ff  <= idx_in;
      byte_ff <= byte_in;
      rl_ff   <= rl_in;
      sl_ff   <= sl_in;
   end

   assign rsp_valid       = rv_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_run_last    = rl_ff;
   assign rsp_string_last = sl_ff;

endmodule

// ----- sv/u16u8_checker.sv -----
// Port-level checks for the transcoder, bound to its top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module u16u8_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_run_last,
   input logic       rsp_string_last
);

   // Result register is empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result byte holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte) &&
                                 $stable(rsp_run_last) && $stable(rsp_string_last))
      else $error("stalled result changed");

   // String end only on a word's final byte
   a_string_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_string_last |-> rsp_run_last)
      else $error("string_last without run_last");

   // A multi-byte lead byte never ends a word
   a_lead_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_out_byte[7:6] == 2'b11) |-> !rsp_run_last)
      else $error("lead byte flagged as last");

endmodule

bind utf16_to_utf8_transcoder u16u8_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_run_last    (rsp_run_last),
   .rsp_string_last (rsp_string_last)
);

// ----- test/testbench.sv -----
// Self-checking testbench for utf16_to_utf8_transcoder: directed and random code units in
// both unit modes, with a built-in UTF-8 predictor. Depends only on the transcoder RTL.
`timescale 1ns / 1ps

module testbench;

   localparam logic MODE_UTF16 = 1'b0;
   localparam logic MODE_UTF32 = 1'b1;

   localparam logic [31:0] REPLACEMENT_POINT = 32'h0000FFFD;
   localparam logic [31:0] MAX_SCALAR        = 32'h0010FFFF;
   localparam logic [15:0] HIGH_FIRST        = 16'hD800;
   localparam logic [15:0] HIGH_LAST         = 16'hDBFF;
   localparam logic [15:0] LOW_FIRST         = 16'hDC00;
   localparam logic [15:0] LOW_LAST          = 16'hDFFF;

   localparam int SETTLE_CYCLES  = 10;
   localparam int HOLD_CYCLES    = 90;
   localparam int DRAIN_LIMIT    = 4000;
   localparam int REPORT_LIMIT   = 10;

   typedef struct packed {
      logic [7:0] data;
      logic       run_end;
      logic       str_end;
   } utf8_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_code_unit = '0;
   logic        req_end_of_string = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_run_last;
   logic        rsp_string_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_unit_mode = 1'b0;

   // Predictor state
   logic          mode_now = MODE_UTF16;
   logic          surrogate_held = 1'b0;
   logic [9:0]    held_bits = '0;
   logic [7:0]    staged [6];
   int            staged_count;
   utf8_byte_type expected_bytes[$];

   int          failure_count = 0;
   int          burst_left = 0;
   bit          hold_request = 1'b0;
   int          hold_left = 0;
   int          stall_cycle = 0;

   utf16_to_utf8_transcoder dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_code_unit     (req_code_unit),
      .req_end_of_string (req_end_of_string),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_run_last      (rsp_run_last),
      .rsp_string_last   (rsp_string_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_unit_mode     (csr_unit_mode)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Append the UTF-8 encoding of one code point to the staged bytes
   function automatic void stage_point(input logic [31:0] point);
      logic [31:0] cp;
      cp = point;
      if (cp > MAX_SCALAR || (cp >= {16'h0, HIGH_FIRST} && cp <= {16'h0, LOW_LAST})) begin
         cp = REPLACEMENT_POINT;
      end
      if (cp <= 32'h7F) begin
         staged[staged_count] = cp[7:0];
         staged_count += 1;
      end else if (cp <= 32'h7FF) begin
         staged[staged_count]     = {3'b110, cp[10:6]};
         staged[staged_count + 1] = {2'b10, cp[5:0]};
         staged_count += 2;
      end else if (cp <= 32'hFFFF) begin
         staged[staged_count]     = {4'b1110, cp[15:12]};
         staged[staged_count + 1] = {2'b10, cp[11:6]};
         staged[staged_count + 2] = {2'b10, cp[5:0]};
         staged_count += 3;
      end else begin
         staged[staged_count]     = {5'b11110, cp[20:18]};
         staged[staged_count + 1] = {2'b10, cp[17:12]};
         staged[staged_count + 2] = {2'b10, cp[11:6]};
         staged[staged_count + 3] = {2'b10, cp[5:0]};
         staged_count += 4;
      end
   endfunction

   // Work out the bytes that one accepted word produces and queue them
   function automatic void predict_utf8_bytes(input logic [31:0] unit, input logic eos);
      logic [15:0]   half;
      bit            paired;
      utf8_byte_type b;
      staged_count = 0;
      paired = 1'b0;
      if (mode_now == MODE_UTF32) begin
         stage_point(unit);
      end else begin
         half = unit[15:0];
         if (surrogate_held) begin
            surrogate_held = 1'b0;
            if (half >= LOW_FIRST && half <= LOW_LAST) begin
               stage_point(32'h10000 + {12'h0, held_bits, 10'h0} + {22'h0, half[9:0]});
               paired = 1'b1;
            end else begin
               stage_point(REPLACEMENT_POINT);
            end
            held_bits = '0;
         end
         if (!paired) begin
            if (half >= HIGH_FIRST && half <= HIGH_LAST) begin
               if (eos) begin
                  stage_point(REPLACEMENT_POINT);
               end else begin
                  held_bits = half[9:0];
                  surrogate_held = 1'b1;
               end
            end else begin
               stage_point({16'h0, half});
            end
         end
      end
      for (int i = 0; i < staged_count; i++) begin
         b.data    = staged[i];
         b.run_end = (i == staged_count - 1);
         b.str_end = (i == staged_count - 1) && eos;
         expected_bytes = {expected_bytes, b};
      end
   endfunction

   // Offer one word, with bursts and random gaps, and predict it once accepted
   task automatic send_unit(input logic [31:0] unit, input logic eos);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left -= 1;
      req_valid         <= 1'b1;
      req_code_unit     <= unit;
      req_end_of_string <= eos;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_utf8_bytes(unit, eos);
   endtask

   // Drop valid and wait until every expected byte is out and the block is quiet
   task automatic drain;
      req_valid <= 1'b0;
      burst_left = 0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the mode register while idle; a write drops any held surrogate
   task automatic write_unit_mode(input logic mode);
      drain();
      csr_valid     <= 1'b1;
      csr_unit_mode <= mode;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid      <= 1'b0;
      mode_now       = mode;
      surrogate_held = 1'b0;
      held_bits      = '0;
   endtask

   // Random high bits that mode 0 must ignore
   function automatic logic [15:0] noise_upper();
      return ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'h0;
   endfunction

   // One string of 16-bit units: mostly well-formed characters, some broken surrogates
   task automatic send_utf16_string(input int length);
      int          kind;
      logic        last;
      logic [15:0] half;
      for (int i = 0; i < length; i++) begin
         last = (i == length - 1);
         kind = $urandom_range(0, 99);
         if (kind < 25) begin
            half = 16'($urandom_range(0, 16'h7F));
         end else if (kind < 40) begin
            half = 16'($urandom_range(16'h80, 16'h7FF));
         end else if (kind < 60) begin
            half = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(16'h800, 16'hD7FF))
                                               : 16'($urandom_range(16'hE000, 16'hFFFF));
         end else if (kind < 85) begin
            send_unit({noise_upper(), 16'($urandom_range(HIGH_FIRST, HIGH_LAST))}, 1'b0);
            half = 16'($urandom_range(LOW_FIRST, LOW_LAST));
         end else if (kind < 92) begin
            half = 16'($urandom_range(HIGH_FIRST, HIGH_LAST));
         end else if (kind < 97) begin
            half = 16'($urandom_range(LOW_FIRST, LOW_LAST));
         end else begin
            half = 16'($urandom);
         end
         send_unit({noise_upper(), half}, last);
      end
   endtask

   // One string of 32-bit units across all encoding lengths plus invalid scalars
   task automatic send_utf32_string(input int length);
      int          kind;
      logic [31:0] unit;
      for (int i = 0; i < length; i++) begin
         kind = $urandom_range(0, 99);
         if (kind < 20) begin
            unit = $urandom_range(0, 32'h7F);
         end else if (kind < 35) begin
            unit = $urandom_range(32'h80, 32'h7FF);
         end else if (kind < 55) begin
            unit = $urandom_range(32'h800, 32'hFFFF);
         end else if (kind < 75) begin
            unit = $urandom_range(32'h10000, MAX_SCALAR);
         end else if (kind < 83) begin
            unit = $urandom_range(32'hD800, 32'hDFFF);
         end else if (kind < 91) begin
            unit = $urandom_range(32'h110000, 32'hFFFFFFFF);
         end else begin
            unit = $urandom;
         end
         send_unit(unit, i == length - 1);
      end
   endtask

   // Encoding boundaries and every surrogate case in 16-bit mode
   task automatic test_utf16_directed;
      send_unit(32'h0000_0000, 1'b0);
      send_unit(32'h0000_007F, 1'b0);
      send_unit(32'h0000_0080, 1'b0);
      send_unit(32'h0000_07FF, 1'b0);
      send_unit(32'h0000_0800, 1'b0);
      send_unit(32'hFFFF_0041, 1'b0);
      send_unit(32'h0000_FFFF, 1'b1);
      // pairs at both ends of the supplementary range
      send_unit(32'h0000_D800, 1'b0);
      send_unit(32'h0000_DC00, 1'b0);
      send_unit(32'h0000_DBFF, 1'b0);
      send_unit(32'h0000_DFFF, 1'b1);
      // lone low surrogate
      send_unit(32'h0000_DC00, 1'b0);
      // held high surrogate followed by a plain unit, then by another high one
      send_unit(32'h0000_D801, 1'b0);
      send_unit(32'h0000_0041, 1'b0);
      send_unit(32'h0000_D802, 1'b0);
      send_unit(32'h0000_DBFE, 1'b0);
      send_unit(32'h0000_DC05, 1'b1);
      // high surrogate at string end, and a held one closed by a plain final unit
      send_unit(32'h0000_DBFF, 1'b1);
      send_unit(32'h0000_D803, 1'b0);
      send_unit(32'h0000_FFFD, 1'b1);
   endtask

   // Length boundaries and invalid scalars in 32-bit mode
   task automatic test_utf32_directed;
      send_unit(32'h0000_0000, 1'b0);
      send_unit(32'h0000_07FF, 1'b0);
      send_unit(32'h0000_0800, 1'b0);
      send_unit(32'h0000_D800, 1'b0);
      send_unit(32'h0000_DFFF, 1'b0);
      send_unit(32'h0001_0000, 1'b0);
      send_unit(MAX_SCALAR, 1'b0);
      send_unit(32'h0011_0000, 1'b0);
      send_unit(32'hFFFF_FFFF, 1'b1);
   endtask

   // A register write drops a held high surrogate, so the next low one stands alone
   task automatic test_write_discards_held;
      send_unit(32'h0000_DA55, 1'b0);
      write_unit_mode(MODE_UTF16);
      send_unit(32'h0000_DE77, 1'b1);
   endtask

   task automatic test_utf16_random(input int strings);
      for (int s = 0; s < strings; s++) send_utf16_string($urandom_range(1, 8));
   endtask

   task automatic test_utf32_random(input int strings);
      for (int s = 0; s < strings; s++) send_utf32_string($urandom_range(1, 8));
   endtask

   // Hold the result side off for a long stretch while words keep coming
   task automatic test_backpressure;
      hold_request = 1'b1;
      for (int s = 0; s < 8; s++) send_utf16_string($urandom_range(3, 6));
   endtask

   // Receiver stall pattern: calm, light, heavy and periodic stretches, plus long holds
   always @(posedge clock) begin
      logic stall_next;
      stall_cycle += 1;
      if (hold_request && hold_left == 0) begin
         hold_left    = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left -= 1;
         stall_next = 1'b1;
      end else begin
         case ((stall_cycle / 48) % 4)
            0: stall_next = 1'b0;
            1: stall_next = ($urandom_range(0, 3) == 0);
            2: stall_next = ($urandom_range(0, 3) != 0);
            default: stall_next = ((stall_cycle % 7) < 3);
         endcase
      end
      rsp_stall <= stall_next;
   end

   // Compare each accepted byte with the oldest expected one
   always @(posedge clock) begin
      utf8_byte_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_bytes.size() == 0) begin
            failure_count += 1;
            if (failure_count <= REPORT_LIMIT) begin
               $display("unexpected byte %02h run_last %b string_last %b at %0t",
                        rsp_out_byte, rsp_run_last, rsp_string_last, $realtime);
            end
         end else begin
            want = expected_bytes.pop_front();
            if (want.data !== rsp_out_byte || want.run_end !== rsp_run_last
                || want.str_end !== rsp_string_last) begin
               failure_count += 1;
               if (failure_count <= REPORT_LIMIT) begin
                  $display("mismatch at %0t: expected %02h/%b/%b, got %02h/%b/%b",
                           $realtime, want.data, want.run_end, want.str_end,
                           rsp_out_byte, rsp_run_last, rsp_string_last);
               end
            end
         end
      end
   end

   // Run the tests in turn, then settle and report
   initial begin
      int waited;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_utf16_directed();
      write_unit_mode(MODE_UTF32);
      test_utf32_directed();
      test_utf32_random(28);
      write_unit_mode(MODE_UTF16);
      test_write_discards_held();
      test_utf16_random(28);
      test_backpressure();
      write_unit_mode(MODE_UTF32);
      test_utf32_random(10);
      write_unit_mode(MODE_UTF16);
      test_utf16_random(10);
      req_valid <= 1'b0;
      waited = 0;
      while (expected_bytes.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited += 1;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_bytes.size() != 0) begin
         if (failure_count < REPORT_LIMIT) begin
            $display("%0d expected bytes never arrived", expected_bytes.size());
         end
         failure_count += expected_bytes.size();
      end
      if (failure_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
